FILE: hdl/unique_key_ordered_set_table_core_assert.svh
// Assertion macros for the ordered set table core.
// Included by the top level; relies on clk_i and rst_ni in the including scope.
`ifndef UNIQUE_KEY_ORDERED_SET_TABLE_CORE_ASSERT_SVH
`define UNIQUE_KEY_ORDERED_SET_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define UKOST_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define UKOST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/ukost_pkg.sv
// Shared types and constants for the ordered set table core.
// No dependencies; used by ukost_cell and the top level.
package ukost_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned FUNC_W   = 3;

  // Operation codes
  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT = 3'd0,
    FN_REMOVE = 3'd1,
    FN_LOOKUP = 3'd2,
    FN_FIRST  = 3'd3,
    FN_NEXT   = 3'd4
  } func_e;

  // Sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic             ins_en;
    logic             rem_en;
    logic [KEY_W-1:0] key;
  } cell_ctrl_t;

endpackage

FILE: hdl/ukost_cell.sv
// One storage cell of the ordered set row: holds a key, compares it,
// shifts down on remove and takes the key at the tail on insert. Depends on ukost_pkg.
module ukost_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 5
) (
  input  logic                            clk_i,
  input  ukost_pkg::cell_ctrl_t           ctrl_i,
  input  logic [CW-1:0]                   count_i,
  input  logic [CW-1:0]                   rd_idx_i,
  input  logic [ukost_pkg::KEY_W-1:0]     nbr_key_i,
  input  logic                            hit_i,
  input  logic [ukost_pkg::KEY_W-1:0]     rd_i,
  output logic [ukost_pkg::KEY_W-1:0]     key_o,
  output logic                            hit_o,
  output logic [ukost_pkg::KEY_W-1:0]     rd_o
);

  logic [ukost_pkg::KEY_W-1:0] key_q, key_d;
  logic                        valid;
  logic                        match;

  // A cell holds a live key only below the fill count
  assign valid = (CW'(IDX) < count_i);
  assign match = valid && (key_q == ctrl_i.key);

  // Pass the running hit flag up the row
  assign hit_o = hit_i | match;

  // Pick this cell's key when the read index lands here
  assign rd_o  = (valid && (CW'(IDX) == rd_idx_i)) ? key_q : rd_i;
  assign key_o = key_q;

  // Shift down from the neighbor at or above a removed key; append at the tail
  always_comb begin
    key_d = key_q;
    if (ctrl_i.rem_en && hit_o) begin
      key_d = nbr_key_i;
    end else if (ctrl_i.ins_en && (CW'(IDX) == count_i)) begin
      key_d = ctrl_i.key;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

FILE: hdl/unique_key_ordered_set_table_core.sv
// Ordered set of distinct keys held in a row of compare-and-shift cells.
// A beat accepted while idle moves the sequencer into its execute state, and the result strobe
// is registered from that state. No new operation is taken while busy in the execute state,
// in which the whole cell row compares, shifts and selects the read key.
// Reset clears fill count, read cursor and sequencer; stored keys are left undefined.
// The receiver cannot stall: each result stands on the ports for one cycle.
module unique_key_ordered_set_table_core #(
  parameter int unsigned CAPACITY = ukost_pkg::CAPACITY
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [ukost_pkg::FUNC_W-1:0]           func_i,
  input  logic signed [ukost_pkg::KEY_W-1:0]     key_i,
  output logic                                   done_o,
  output logic                                   ok_o,
  output logic signed [ukost_pkg::KEY_W-1:0]     value_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  ukost_pkg::state_e            state_q, state_d;
  ukost_pkg::func_e             func_q;
  logic [ukost_pkg::KEY_W-1:0]  key_q;
  logic [CW-1:0]                count_q, count_d;
  logic [CW-1:0]                cursor_q, cursor_d;
  logic                         done_q, done_d;
  logic                         ok_q, ok_d;
  logic [ukost_pkg::KEY_W-1:0]  value_q, value_d;

  logic                         accept;
  logic                         exec;
  logic                         found;
  logic                         full;
  logic [CW-1:0]                rd_idx;
  logic [CW-1:0]                next_cur;
  ukost_pkg::cell_ctrl_t        ctrl;

  logic [ukost_pkg::KEY_W-1:0]  key_link [CAPACITY];
  logic [ukost_pkg::KEY_W-1:0]  rd_link  [CAPACITY+1];
  logic                         hit_link [CAPACITY+1];

  assign accept = start && !busy;
  assign exec   = (state_q == ukost_pkg::ST_EXEC);
  assign full   = (count_q >= CW'(CAPACITY));
  assign found  = hit_link[CAPACITY];

  // Cursor after a read next: advance while inside, else park past the end
  assign next_cur = (cursor_q < count_q) ? (cursor_q + CW'(1)) : count_q;

  // Broadcast the command to the row
  always_comb begin
    ctrl.key    = key_q;
    ctrl.ins_en = exec && (func_q == ukost_pkg::FN_INSERT) && !full && !found;
    ctrl.rem_en = exec && (func_q == ukost_pkg::FN_REMOVE);
    rd_idx      = (func_q == ukost_pkg::FN_NEXT) ? next_cur : '0;
  end

  // Cell row
  assign hit_link[0] = 1'b0;
  assign rd_link[0]  = '0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [ukost_pkg::KEY_W-1:0] nbr_key;
    if (g == CAPACITY - 1) begin : g_tail
      assign nbr_key = key_link[g];
    end else begin : g_body
      assign nbr_key = key_link[g+1];
    end

    ukost_cell #(
      .IDX (g),
      .CW  (CW)
    ) u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .count_i   (count_q),
      .rd_idx_i  (rd_idx),
      .nbr_key_i (nbr_key),
      .hit_i     (hit_link[g]),
      .rd_i      (rd_link[g]),
      .key_o     (key_link[g]),
      .hit_o     (hit_link[g+1]),
      .rd_o      (rd_link[g+1])
    );
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ukost_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = ukost_pkg::ST_EXEC;
        end
      end
      ukost_pkg::ST_EXEC: begin
        state_d = ukost_pkg::ST_IDLE;
      end
      default: begin
        state_d = ukost_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs and table bookkeeping
  always_comb begin
    busy     = 1'b0;
    count_d  = count_q;
    cursor_d = cursor_q;
    done_d   = 1'b0;
    ok_d     = 1'b0;
    value_d  = '0;
    case (state_q)
      ukost_pkg::ST_IDLE: begin
        busy = 1'b0;
      end
      ukost_pkg::ST_EXEC: begin
        busy   = 1'b1;
        done_d = 1'b1;
        case (func_q)
          ukost_pkg::FN_INSERT: begin
            if (!full) begin
              cursor_d = '0;
              if (!found) begin
                count_d = count_q + CW'(1);
                ok_d    = 1'b1;
              end
            end
          end
          ukost_pkg::FN_REMOVE: begin
            if (count_q != '0) begin
              if (!found) begin
                cursor_d = count_q;
              end else begin
                count_d  = count_q - CW'(1);
                cursor_d = '0;
                ok_d     = 1'b1;
              end
            end
          end
          ukost_pkg::FN_LOOKUP: begin
            ok_d     = found;
            cursor_d = '0;
          end
          ukost_pkg::FN_FIRST: begin
            if (count_q != '0) begin
              cursor_d = '0;
              ok_d     = 1'b1;
              value_d  = rd_link[CAPACITY];
            end
          end
          ukost_pkg::FN_NEXT: begin
            if (count_q != '0) begin
              cursor_d = next_cur;
              if (next_cur < count_q) begin
                ok_d    = 1'b1;
                value_d = rd_link[CAPACITY];
              end
            end
          end
          default: begin
            ok_d = 1'b0;
          end
        endcase
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ukost_pkg::ST_IDLE;
      count_q  <= '0;
      cursor_q <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      cursor_q <= cursor_d;
      done_q   <= done_d;
    end
  end

  // Capture the command beat and hold the result beat
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= ukost_pkg::func_e'(func_i);
      key_q  <= key_i;
    end
    ok_q    <= ok_d;
    value_q <= value_d;
  end

  assign done_o  = done_q;
  assign ok_o    = ok_q;
  assign value_o = value_q;

  // Checks
  `include "unique_key_ordered_set_table_core_assert.svh"

  `UKOST_ASSERT_NEXT(a_exec_strobes, exec, done_o, "execute cycle not followed by a result")
  `UKOST_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(CAPACITY), "fill count above capacity")
  `UKOST_ASSERT_NOW(a_cursor_bound, 1'b1, cursor_q <= count_q, "read cursor beyond fill count")
  `UKOST_ASSERT_NOW(a_fail_zero, done_o && !ok_o, value_o == '0, "failed result with nonzero value")

endmodule
